// File: rtl/core/skvm_pkg.sv
package skvm_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic signed [31:0] SENTINEL_KEY = 32'sh7FFF_FFFF;

    localparam logic [1:0] ACT_LOOKUP = 2'd0;
    localparam logic [1:0] ACT_INSERT = 2'd1;
    localparam logic [1:0] ACT_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_INVALID   = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_CMP,
        S_INS,
        S_INS_WR,
        S_DEL,
        S_DEL_WR
    } t_state;

    // read address relative to the pointer
    typedef enum logic [1:0] {
        RA_PTR,
        RA_PTR_M1,
        RA_PTR_P1
    } t_rd_src;

    typedef enum logic [1:0] {
        P_HOLD,
        P_INC,
        P_DEC,
        P_TO_COUNT
    } t_ptr_op;

    typedef struct packed {
        logic    load;
        logic    rd;
        t_rd_src rd_src;
        logic    wr;
        logic    wr_new;
        t_ptr_op ptr_op;
        logic    pos_save;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_we;
        logic    res_found;
        logic    res_take_val;
        t_status res_status;
    } t_cmd;

    typedef struct packed {
        logic       sentinel;
        logic [1:0] action;
        logic       at_end;
        logic       key_lt;
        logic       key_eq;
        logic       full;
        logic       ins_done;
        logic       del_done;
    } t_stat;

endpackage

// File: rtl/core/skvm_ctrl.sv
module skvm_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  skvm_pkg::t_stat  i_stat,
    output skvm_pkg::t_cmd   o_cmd,
    output logic             o_busy
);

    skvm_pkg::t_state r_state;
    skvm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skvm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != skvm_pkg::S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            skvm_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = skvm_pkg::S_CHECK;
                end
            end
            skvm_pkg::S_CHECK: begin
                if (i_stat.sentinel) begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = skvm_pkg::ST_INVALID;
                    n_state          = skvm_pkg::S_IDLE;
                end else if (i_stat.action == skvm_pkg::ACT_LOOKUP ||
                             i_stat.action == skvm_pkg::ACT_INSERT ||
                             i_stat.action == skvm_pkg::ACT_DELETE) begin
                    n_state = skvm_pkg::S_SCAN;
                end else begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = skvm_pkg::ST_NOT_FOUND;
                    n_state          = skvm_pkg::S_IDLE;
                end
            end
            skvm_pkg::S_SCAN: begin
                if (i_stat.at_end) begin
                    // ran off the end: miss, insert position is the count
                    if (i_stat.action == skvm_pkg::ACT_INSERT) begin
                        if (i_stat.full) begin
                            o_cmd.res_we     = 1'b1;
                            o_cmd.res_status = skvm_pkg::ST_FULL;
                            n_state          = skvm_pkg::S_IDLE;
                        end else begin
                            o_cmd.pos_save = 1'b1;
                            o_cmd.ptr_op   = skvm_pkg::P_TO_COUNT;
                            n_state        = skvm_pkg::S_INS;
                        end
                    end else begin
                        o_cmd.res_we     = 1'b1;
                        o_cmd.res_status = skvm_pkg::ST_NOT_FOUND;
                        n_state          = skvm_pkg::S_IDLE;
                    end
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_src = skvm_pkg::RA_PTR;
                    n_state      = skvm_pkg::S_CMP;
                end
            end
            skvm_pkg::S_CMP: begin
                if (i_stat.key_lt) begin
                    o_cmd.ptr_op = skvm_pkg::P_INC;
                    n_state      = skvm_pkg::S_SCAN;
                end else if (i_stat.key_eq) begin
                    if (i_stat.action == skvm_pkg::ACT_DELETE) begin
                        n_state = skvm_pkg::S_DEL;
                    end else begin
                        // lookup returns the value, insert overwrites it
                        o_cmd.wr           = (i_stat.action == skvm_pkg::ACT_INSERT);
                        o_cmd.wr_new       = 1'b1;
                        o_cmd.res_we       = 1'b1;
                        o_cmd.res_found    = 1'b1;
                        o_cmd.res_take_val = (i_stat.action == skvm_pkg::ACT_LOOKUP);
                        o_cmd.res_status   = skvm_pkg::ST_OK;
                        n_state            = skvm_pkg::S_IDLE;
                    end
                end else if (i_stat.action == skvm_pkg::ACT_INSERT) begin
                    if (i_stat.full) begin
                        o_cmd.res_we     = 1'b1;
                        o_cmd.res_status = skvm_pkg::ST_FULL;
                        n_state          = skvm_pkg::S_IDLE;
                    end else begin
                        o_cmd.pos_save = 1'b1;
                        o_cmd.ptr_op   = skvm_pkg::P_TO_COUNT;
                        n_state        = skvm_pkg::S_INS;
                    end
                end else begin
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = skvm_pkg::ST_NOT_FOUND;
                    n_state          = skvm_pkg::S_IDLE;
                end
            end
            skvm_pkg::S_INS: begin
                if (i_stat.ins_done) begin
                    o_cmd.wr         = 1'b1;
                    o_cmd.wr_new     = 1'b1;
                    o_cmd.cnt_inc    = 1'b1;
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_status = skvm_pkg::ST_OK;
                    n_state          = skvm_pkg::S_IDLE;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_src = skvm_pkg::RA_PTR_M1;
                    n_state      = skvm_pkg::S_INS_WR;
                end
            end
            skvm_pkg::S_INS_WR: begin
                o_cmd.wr     = 1'b1;
                o_cmd.ptr_op = skvm_pkg::P_DEC;
                n_state      = skvm_pkg::S_INS;
            end
            skvm_pkg::S_DEL: begin
                if (i_stat.del_done) begin
                    o_cmd.cnt_dec    = 1'b1;
                    o_cmd.res_we     = 1'b1;
                    o_cmd.res_found  = 1'b1;
                    o_cmd.res_status = skvm_pkg::ST_OK;
                    n_state          = skvm_pkg::S_IDLE;
                end else begin
                    o_cmd.rd     = 1'b1;
                    o_cmd.rd_src = skvm_pkg::RA_PTR_P1;
                    n_state      = skvm_pkg::S_DEL_WR;
                end
            end
            skvm_pkg::S_DEL_WR: begin
                o_cmd.wr     = 1'b1;
                o_cmd.ptr_op = skvm_pkg::P_INC;
                n_state      = skvm_pkg::S_DEL;
            end
            default: begin
                n_state = skvm_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: rtl/core/skvm_dpath.sv
module skvm_dpath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  skvm_pkg::t_cmd      i_cmd,
    input  logic [1:0]          i_action,
    input  logic signed [31:0]  i_key,
    input  logic signed [31:0]  i_value,
    output skvm_pkg::t_stat     o_stat,
    output logic                o_valid,
    output logic                o_found,
    output logic signed [31:0]  o_read_value,
    output logic [1:0]          o_status
);

    logic [31:0] r_key_mem [skvm_pkg::CAPACITY];
    logic [31:0] r_val_mem [skvm_pkg::CAPACITY];

    logic [1:0]                  r_action;
    logic signed [31:0]          r_key;
    logic signed [31:0]          r_val;
    logic [skvm_pkg::CNT_W-1:0]  r_count;
    logic [skvm_pkg::CNT_W-1:0]  r_ptr;
    logic [skvm_pkg::CNT_W-1:0]  r_pos;
    logic signed [31:0]          r_rd_key;
    logic signed [31:0]          r_rd_val;
    logic                        r_valid;
    logic                        r_found;
    logic signed [31:0]          r_rv;
    logic [1:0]                  r_status;

    logic [skvm_pkg::CNT_W-1:0]  rd_ptr;
    logic [skvm_pkg::IDX_W-1:0]  rd_addr;
    logic [skvm_pkg::IDX_W-1:0]  wr_addr;
    logic [skvm_pkg::CNT_W-1:0]  ptr_p1;

    assign ptr_p1 = r_ptr + skvm_pkg::CNT_W'(1);

    always_comb begin
        case (i_cmd.rd_src)
            skvm_pkg::RA_PTR_M1: rd_ptr = r_ptr - skvm_pkg::CNT_W'(1);
            skvm_pkg::RA_PTR_P1: rd_ptr = ptr_p1;
            default:             rd_ptr = r_ptr;
        endcase
    end

    assign rd_addr = rd_ptr[skvm_pkg::IDX_W-1:0];
    assign wr_addr = r_ptr[skvm_pkg::IDX_W-1:0];

    // store arrays: one read and one write port each
    always_ff @(posedge i_clk) begin
        if (i_cmd.rd) begin
            r_rd_key <= r_key_mem[rd_addr];
            r_rd_val <= r_val_mem[rd_addr];
        end
        if (i_cmd.wr) begin
            r_key_mem[wr_addr] <= i_cmd.wr_new ? r_key : r_rd_key;
            r_val_mem[wr_addr] <= i_cmd.wr_new ? r_val : r_rd_val;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_action <= i_action;
            r_key    <= i_key;
            r_val    <= i_value;
        end
        if (i_cmd.pos_save) begin
            r_pos <= r_ptr;
        end
        if (i_cmd.res_we) begin
            r_found  <= i_cmd.res_found;
            r_rv     <= i_cmd.res_take_val ? r_rd_val : 32'sd0;
            r_status <= i_cmd.res_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ptr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_cmd.res_we;
            if (i_cmd.cnt_inc) begin
                r_count <= r_count + skvm_pkg::CNT_W'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= r_count - skvm_pkg::CNT_W'(1);
            end
            if (i_cmd.load) begin
                r_ptr <= '0;
            end else begin
                case (i_cmd.ptr_op)
                    skvm_pkg::P_INC:      r_ptr <= ptr_p1;
                    skvm_pkg::P_DEC:      r_ptr <= r_ptr - skvm_pkg::CNT_W'(1);
                    skvm_pkg::P_TO_COUNT: r_ptr <= r_count;
                    default:              r_ptr <= r_ptr;
                endcase
            end
        end
    end

    assign o_stat.sentinel = (r_key == skvm_pkg::SENTINEL_KEY);
    assign o_stat.action   = r_action;
    assign o_stat.at_end   = (r_ptr == r_count);
    assign o_stat.key_lt   = (r_rd_key < r_key);
    assign o_stat.key_eq   = (r_rd_key == r_key);
    assign o_stat.full     = (r_count == skvm_pkg::CNT_W'(skvm_pkg::CAPACITY));
    assign o_stat.ins_done = (r_ptr == r_pos);
    assign o_stat.del_done = (ptr_p1 >= r_count);

    assign o_valid      = r_valid;
    assign o_found      = r_found;
    assign o_read_value = r_rv;
    assign o_status     = r_status;

endmodule

// File: rtl/core/sorted_key_value_map_core.sv
// Ordered key-value map of 64 entries held sorted by signed key in a pair of
// single-port-read arrays. Raise start with i_action (0 lookup, 1 insert or
// update, 2 delete), i_key and i_value; the transfer happens on the edge where
// start is high and busy is low. Exactly one result per request comes back as
// a single-cycle o_valid pulse carrying o_found, o_read_value and o_status
// (0 ok, 1 not found, 2 full, 3 invalid key). The receiver cannot stall, so
// capture the result in the cycle o_valid is high. Key 2147483647 is reserved
// and always rejected; action 3 changes nothing and reports not found.
// The search walks the sorted store from the bottom, reading each entry visited
// from the array and then comparing it. An insert of a new key then moves every
// higher entry up by one and a delete moves them down, each move being one array
// read followed by one write. Busy stays high throughout.
// No clearing pass is needed after reset: only entries below the count are read.
module sorted_key_value_map_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_action,
    input  logic signed [31:0] i_key,
    input  logic signed [31:0] i_value,
    output logic               o_valid,
    output logic               o_found,
    output logic signed [31:0] o_read_value,
    output logic [1:0]         o_status
);

    skvm_pkg::t_cmd  cmd;
    skvm_pkg::t_stat stat;

    // sequencing: search, shift and result commands
    skvm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .o_busy  (busy)
    );

    // storage, pointer, count and result registers
    skvm_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_action     (i_action),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_stat       (stat),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_read_value (o_read_value),
        .o_status     (o_status)
    );

    // an accepted request keeps the block busy on the next cycle
    a_busy_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy low after accepted request");

    // the block returns to idle after every result, so results never come back to back
    a_single_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for two cycles");

    // only a successful lookup carries a value; failures never report found
    a_value_needs_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_read_value != 32'sd0) |-> (o_found && o_status == skvm_pkg::ST_OK))
        else $error("value returned without a hit");

    a_fail_not_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != skvm_pkg::ST_OK) |-> !o_found)
        else $error("failed request reports found");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    // Action 3 has no name in the package; it must change nothing.
    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 1250;
    localparam int POOL_SIZE       = 96;   // more keys than slots, so the store fills
    localparam int CHUNK_LEN       = 40;
    // Allow a worst-case request with a wide margin plus sender gaps.
    localparam int DRAIN_CYCLES    = 160;
    localparam int WATCHDOG_LIMIT  = 2000;

    typedef struct {
        logic [1:0]         action;
        logic signed [31:0] key;
        logic signed [31:0] value;
    } t_map_request;

    typedef struct {
        logic               found;
        logic signed [31:0] read_value;
        skvm_pkg::t_status  status;
    } t_map_reply;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [1:0]         i_action = skvm_pkg::ACT_LOOKUP;
    logic signed [31:0] i_key = '0;
    logic signed [31:0] i_value = '0;
    logic               o_valid;
    logic               o_found;
    logic signed [31:0] o_read_value;
    logic [1:0]         o_status;

    sorted_key_value_map_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_action     (i_action),
        .i_key        (i_key),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .o_found      (o_found),
        .o_read_value (o_read_value),
        .o_status     (o_status)
    );

    // Shadow copy of the sorted store: keys ascending, values alongside.
    logic signed [31:0] map_keys [skvm_pkg::CAPACITY];
    logic signed [31:0] map_vals [skvm_pkg::CAPACITY];
    int                 map_count = 0;

    t_map_request       pending_requests [$];
    t_map_reply         replies_due [$];
    t_map_request       next_req;
    logic signed [31:0] key_pool [POOL_SIZE];

    int total_requests = 0;
    int requests_accepted = 0;
    int replies_checked = 0;
    int mismatches = 0;
    int watchdog_count = 0;
    int n_lookup_hits = 0;
    int n_inserts_new = 0;
    int n_updates = 0;
    int n_delete_hits = 0;
    int n_full = 0;
    int n_invalid = 0;
    int n_not_found = 0;
    int peak_fill = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // Apply one accepted request to the shadow store and queue the reply it must produce.
    task automatic apply_request(input logic [1:0] act, input logic signed [31:0] key,
                                 input logic signed [31:0] val);
        int         pos;
        logic       hit;
        t_map_reply reply;
        reply.found      = 1'b0;
        reply.read_value = '0;
        reply.status     = skvm_pkg::ST_NOT_FOUND;
        if (key == skvm_pkg::SENTINEL_KEY) begin
            reply.status = skvm_pkg::ST_INVALID;
        end else if (act != ACT_UNUSED) begin
            // find the first slot whose key is not below the request key
            pos = 0;
            while (pos < map_count && map_keys[pos] < key) pos++;
            hit = (pos < map_count) && (map_keys[pos] == key);
            case (act)
                skvm_pkg::ACT_LOOKUP: begin
                    if (hit) begin
                        reply.found      = 1'b1;
                        reply.read_value = map_vals[pos];
                        reply.status     = skvm_pkg::ST_OK;
                    end
                end
                skvm_pkg::ACT_INSERT: begin
                    if (hit) begin
                        map_vals[pos] = val;
                        reply.found   = 1'b1;
                        reply.status  = skvm_pkg::ST_OK;
                        n_updates++;
                    end else if (map_count >= skvm_pkg::CAPACITY) begin
                        reply.status = skvm_pkg::ST_FULL;
                    end else begin
                        // open a gap at pos: move higher entries up by one
                        for (int j = map_count; j > pos; j--) begin
                            map_keys[j] = map_keys[j-1];
                            map_vals[j] = map_vals[j-1];
                        end
                        map_keys[pos] = key;
                        map_vals[pos] = val;
                        map_count++;
                        reply.status = skvm_pkg::ST_OK;
                        n_inserts_new++;
                    end
                end
                default: begin
                    if (hit) begin
                        // close the gap: move higher entries down by one
                        for (int j = pos; j < map_count - 1; j++) begin
                            map_keys[j] = map_keys[j+1];
                            map_vals[j] = map_vals[j+1];
                        end
                        map_count--;
                        reply.found  = 1'b1;
                        reply.status = skvm_pkg::ST_OK;
                    end
                end
            endcase
        end
        if (reply.status == skvm_pkg::ST_INVALID) n_invalid++;
        if (reply.status == skvm_pkg::ST_FULL) n_full++;
        if (reply.status == skvm_pkg::ST_NOT_FOUND) n_not_found++;
        if (act == skvm_pkg::ACT_LOOKUP && reply.found) n_lookup_hits++;
        if (act == skvm_pkg::ACT_DELETE && reply.found && key != skvm_pkg::SENTINEL_KEY)
            n_delete_hits++;
        if (map_count > peak_fill) peak_fill = map_count;
        replies_due.push_back(reply);
    endtask

    task automatic add_request(input logic [1:0] act, input logic signed [31:0] key,
                               input logic signed [31:0] val);
        t_map_request req;
        req.action = act;
        req.key    = key;
        req.value  = val;
        pending_requests.push_back(req);
    endtask

    // Mostly keys from the pool so hits and a full store happen; some near misses,
    // some fully random keys, and the occasional reserved key.
    function automatic logic signed [31:0] pick_key();
        int                 roll;
        logic signed [31:0] k;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            k = skvm_pkg::SENTINEL_KEY;
        end else if (roll < 12) begin
            k = $urandom;
        end else if (roll < 16) begin
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)] + ($urandom_range(0, 1) ? 1 : -1);
        end else begin
            k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
        end
        return k;
    endfunction

    // Sender idle rate per cycle: light gaps, then heavy gaps, then back to back.
    function automatic bit sender_rests();
        int pct;
        if (requests_accepted < total_requests / 3) pct = 14;
        else if (requests_accepted < (2 * total_requests) / 3) pct = 56;
        else pct = 0;
        return $urandom_range(0, 99) < pct;
    endfunction

    // Driver: count a transfer when start meets a low busy, then present the next
    // request or drop start. Hold the request steady while the block is busy.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            if (start && !busy) begin
                apply_request(i_action, i_key, i_value);
                requests_accepted++;
            end
            if (!start || !busy) begin
                if (pending_requests.size() > 0 && !sender_rests()) begin
                    next_req = pending_requests.pop_front();
                    start    <= 1'b1;
                    i_action <= next_req.action;
                    i_key    <= next_req.key;
                    i_value  <= next_req.value;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: a result exists for exactly one cycle, so take it on every strobe
    // and compare it against the oldest outstanding reply.
    always @(posedge i_clk) begin
        t_map_reply want;
        if (i_rst_n && o_valid) begin
            if (replies_due.size() == 0) begin
                $display("%0t: unexpected result: found %0b read_value %0d status %0d",
                         $time, o_found, o_read_value, o_status);
                mismatches++;
            end else begin
                want = replies_due.pop_front();
                replies_checked++;
                if (o_found !== want.found) begin
                    $display("%0t: found mismatch: expected %0b actual %0b",
                             $time, want.found, o_found);
                    mismatches++;
                end
                if (o_read_value !== want.read_value) begin
                    $display("%0t: read_value mismatch: expected %0d actual %0d",
                             $time, want.read_value, o_read_value);
                    mismatches++;
                end
                if (o_status !== want.status) begin
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: any cycle with neither a request transfer nor a result advances it.
    always @(posedge i_clk) begin
        if ((start && !busy) || o_valid) begin
            watchdog_count <= 0;
        end else if (watchdog_count >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("testbench: FAIL");
            $finish;
        end else begin
            watchdog_count <= watchdog_count + 1;
        end
    end

    initial begin
        int mode;
        int roll;
        logic [1:0] act;

        // Key pool: the extremes, a dense cluster near zero and scattered wide keys.
        key_pool[0] = 32'sh8000_0000;
        key_pool[1] = 32'sh7FFF_FFFE;
        key_pool[2] = 32'sd0;
        key_pool[3] = -32'sd1;
        for (int i = 4; i < POOL_SIZE; i++) begin
            if (i % 2 == 0) key_pool[i] = $urandom;
            else key_pool[i] = $signed($urandom_range(0, 200)) - 100;
            if (key_pool[i] == skvm_pkg::SENTINEL_KEY)
                key_pool[i] = skvm_pkg::SENTINEL_KEY - 1;
        end

        // Directed opening: empty store misses, extreme keys and values, an update,
        // the reserved key under every action, the unused action, and deletes at
        // both ends of the store.
        add_request(skvm_pkg::ACT_LOOKUP, 32'sd0, 32'sd0);
        add_request(skvm_pkg::ACT_DELETE, 32'sd5, 32'sd0);
        add_request(skvm_pkg::ACT_INSERT, 32'sh8000_0000, 32'sh7FFF_FFFF);
        add_request(skvm_pkg::ACT_INSERT, 32'sh7FFF_FFFE, 32'sh8000_0000);
        add_request(skvm_pkg::ACT_INSERT, 32'sd0, 32'sd0);
        add_request(skvm_pkg::ACT_INSERT, -32'sd1, -32'sd1);
        add_request(skvm_pkg::ACT_LOOKUP, 32'sh8000_0000, 32'sd0);
        add_request(skvm_pkg::ACT_LOOKUP, 32'sh7FFF_FFFE, 32'sd0);
        add_request(skvm_pkg::ACT_LOOKUP, -32'sd1, 32'sd0);
        add_request(skvm_pkg::ACT_INSERT, 32'sd0, 32'sh5A5A_A5A5);
        add_request(skvm_pkg::ACT_LOOKUP, 32'sd0, -32'sd1);
        add_request(skvm_pkg::ACT_LOOKUP, 32'sd1, 32'sd0);
        add_request(skvm_pkg::ACT_LOOKUP, skvm_pkg::SENTINEL_KEY, 32'sd0);
        add_request(skvm_pkg::ACT_INSERT, skvm_pkg::SENTINEL_KEY, 32'sd9);
        add_request(skvm_pkg::ACT_DELETE, skvm_pkg::SENTINEL_KEY, 32'sd0);
        add_request(ACT_UNUSED, skvm_pkg::SENTINEL_KEY, 32'sd0);
        add_request(ACT_UNUSED, 32'sd0, 32'sd3);
        add_request(skvm_pkg::ACT_DELETE, -32'sd1, 32'sd0);
        add_request(skvm_pkg::ACT_DELETE, -32'sd1, 32'sd0);
        add_request(skvm_pkg::ACT_LOOKUP, 32'sh7FFF_FFFE, 32'sd0);
        add_request(skvm_pkg::ACT_DELETE, 32'sh8000_0000, 32'sd0);
        add_request(skvm_pkg::ACT_DELETE, 32'sh7FFF_FFFE, 32'sd0);
        add_request(skvm_pkg::ACT_INSERT, 32'sd7, 32'shA5A5_5A5A);
        add_request(skvm_pkg::ACT_LOOKUP, 32'sd7, 32'sd0);

        // Random part in chunks: fill-heavy runs push the store to capacity,
        // drain runs empty it again, balanced runs mix everything.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            mode = (n / CHUNK_LEN) % 6;
            roll = $urandom_range(0, 99);
            if (roll < 3) begin
                act = ACT_UNUSED;
            end else if (mode <= 2) begin
                act = (roll < 78) ? skvm_pkg::ACT_INSERT :
                      (roll < 92) ? skvm_pkg::ACT_LOOKUP : skvm_pkg::ACT_DELETE;
            end else if (mode == 3) begin
                act = (roll < 38) ? skvm_pkg::ACT_INSERT :
                      (roll < 70) ? skvm_pkg::ACT_LOOKUP : skvm_pkg::ACT_DELETE;
            end else begin
                act = (roll < 15) ? skvm_pkg::ACT_INSERT :
                      (roll < 30) ? skvm_pkg::ACT_LOOKUP : skvm_pkg::ACT_DELETE;
            end
            add_request(act, pick_key(), $urandom);
        end
        total_requests = pending_requests.size();

        // Hold reset, then release it on a rising edge.
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to transfer and every reply to come back,
        // then let the block sit for a worst-case request time.
        while (pending_requests.size() > 0 || start || replies_due.size() > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests, %0d results checked: %0d new keys, %0d updates,",
                 requests_accepted, replies_checked, n_inserts_new, n_updates);
        $display("%0d lookup hits, %0d deletes, %0d misses, %0d full, %0d reserved, peak %0d",
                 n_lookup_hits, n_delete_hits, n_not_found, n_full, n_invalid, peak_fill);
        if (mismatches == 0 && replies_due.size() == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule
